>>> design/ssfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfm_pkg
// Shared types and constants for the first-match substring search block.
// ----------------------------------------------------------------------------
package ssfm_pkg;

    // Needle capacity in bytes and the width of the byte counter
    localparam int MAX_NEEDLE    = 32;
    localparam int POSITION_BITS = 32;

    // Derived widths
    localparam int LEN_W       = 6;   // needle_length register width
    localparam int NEEDLE_IDX_W = $clog2(MAX_NEEDLE);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_WORDS   = 4;   // needle byte words
    localparam int WORD_BYTES  = CFG_DATA_W / 8;
    localparam int MATCH_POS_W = 32;
    localparam int BYTE_W      = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LENGTH = 3'd0,
        CFG_NEEDLE_LO     = 3'd1,
        CFG_NEEDLE_MID    = 3'd2,
        CFG_NEEDLE_HIGH   = 3'd3,
        CFG_NEEDLE_TOP    = 3'd4
    } t_cfg_index;

    // Needle, byte-reversed and aligned to the window, with a care mask
    typedef struct packed {
        logic [LEN_W-1:0]                   len;   // clamped length
        logic [MAX_NEEDLE-1:0]              care;  // window entry takes part
        logic [MAX_NEEDLE-1:0][BYTE_W-1:0]  bytes; // expected window byte
    } t_pattern;

endpackage

>>> design/ssfm_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfm_byte_if
// Valid/ready channel that carries one haystack byte per item.
// ----------------------------------------------------------------------------
interface ssfm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] haystack_byte;

    modport source (output valid, output haystack_byte, input ready);
    modport sink   (input valid, input haystack_byte, output ready);
endinterface

>>> design/ssfm_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfm_result_if
// Valid/ready channel that carries one search result per item.
// ----------------------------------------------------------------------------
interface ssfm_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

>>> design/ssfm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfm_cfg
// Needle register bank; keeps a registered, window-aligned copy of the needle.
// ----------------------------------------------------------------------------
module ssfm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ssfm_pkg::t_pattern            o_pattern
);
    import ssfm_pkg::*;

    logic [LEN_W-1:0]                  r_len_raw;
    logic [CFG_WORDS-1:0][CFG_DATA_W-1:0] r_words;
    t_pattern                          r_pattern;
    t_pattern                          n_pattern;
    logic [MAX_NEEDLE-1:0][BYTE_W-1:0] needle;
    logic [LEN_W-1:0]                  len_clamped;

    // Register writes; indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_raw <= '0;
            r_words   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEEDLE_LENGTH: r_len_raw  <= i_cfg_data[LEN_W-1:0];
                CFG_NEEDLE_LO:     r_words[0] <= i_cfg_data;
                CFG_NEEDLE_MID:    r_words[1] <= i_cfg_data;
                CFG_NEEDLE_HIGH:   r_words[2] <= i_cfg_data;
                CFG_NEEDLE_TOP:    r_words[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte view of the needle words
    always_comb begin
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            needle[j] = r_words[j / WORD_BYTES][(j % WORD_BYTES) * BYTE_W +: BYTE_W];
        end
    end

    // Clamp length, then align: window entry k must equal needle byte len-1-k
    always_comb begin
        logic [LEN_W-1:0] idx;
        len_clamped = (r_len_raw > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : r_len_raw;
        n_pattern.len = len_clamped;
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            idx = len_clamped - LEN_W'(k) - LEN_W'(1);
            n_pattern.care[k]  = (LEN_W'(k) < len_clamped);
            n_pattern.bytes[k] = needle[idx[NEEDLE_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
        end else begin
            r_pattern <= n_pattern;
        end
    end

    assign o_pattern = r_pattern;

endmodule

>>> design/ssfm_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfm_search
// Input register, byte window, counter, parallel compare and result register.
// ----------------------------------------------------------------------------
module ssfm_search (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssfm_pkg::t_pattern i_pattern,
    ssfm_byte_if.sink         i_hay,
    ssfm_result_if.source     o_res
);
    import ssfm_pkg::*;

    localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

    // Input register
    logic                    r_in_valid;
    logic [BYTE_W-1:0]       r_in_byte;
    // Search state
    logic [MAX_NEEDLE-1:0][BYTE_W-1:0] r_win;
    logic [MAX_NEEDLE-1:0][BYTE_W-1:0] n_win;
    logic [POSITION_BITS-1:0] r_count;
    logic [POSITION_BITS-1:0] n_count;
    logic                     r_fin;
    logic                     n_fin;
    // Result register
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [MATCH_POS_W-1:0]   r_out_pos;

    logic                     out_free;
    logic                     proc;
    logic                     in_ready;
    logic                     is_nul;
    logic [POSITION_BITS-1:0] count_inc;
    logic [POSITION_BITS-1:0] len_ext;
    logic [MAX_NEEDLE-1:0]    byte_ok;
    logic                     hit;
    logic                     emit;
    logic                     emit_found;
    logic [POSITION_BITS-1:0] emit_pos;
    logic                     clear;

    // Pipeline control: result slot free or being drained
    assign out_free = !r_out_valid || o_res.ready;
    assign proc     = r_in_valid && out_free;
    assign in_ready = !r_in_valid || proc;
    assign i_hay.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_hay.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_hay.valid) begin
            r_in_byte <= i_hay.haystack_byte;
        end
    end

    // Window shifted by the new byte, and parallel compare against the needle
    assign is_nul    = (r_in_byte == '0);
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + POSITION_BITS'(1);
    assign len_ext   = POSITION_BITS'(i_pattern.len);

    always_comb begin
        n_win[0] = r_in_byte;
        for (int k = 1; k < MAX_NEEDLE; k++) begin
            n_win[k] = r_win[k-1];
        end
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            byte_ok[k] = !i_pattern.care[k] || (n_win[k] == i_pattern.bytes[k]);
        end
    end

    assign hit = (&byte_ok) && (count_inc >= len_ext);

    // Per-item decision
    always_comb begin
        emit       = 1'b0;
        emit_found = 1'b0;
        emit_pos   = '0;
        clear      = 1'b0;
        n_fin      = r_fin;
        if (r_fin) begin
            if (is_nul) begin
                n_fin = 1'b0;
                clear = 1'b1;
            end
        end else if (i_pattern.len == '0) begin
            // empty needle matches at the first byte
            emit       = 1'b1;
            emit_found = 1'b1;
            if (is_nul) begin
                clear = 1'b1;
            end else begin
                n_fin = 1'b1;
            end
        end else if (is_nul) begin
            emit  = 1'b1;
            clear = 1'b1;
        end else if (hit) begin
            emit       = 1'b1;
            emit_found = 1'b1;
            emit_pos   = count_inc - len_ext;
            n_fin      = 1'b1;
        end
        if (clear) begin
            n_count = '0;
        end else if (!r_fin && (i_pattern.len != '0)) begin
            n_count = count_inc;
        end else begin
            n_count = r_count;
        end
    end

    // Window only shifts for bytes that are searched; entries past the
    // count are never compared, so it needs no clearing
    always_ff @(posedge i_clk) begin
        if (proc && !r_fin && (i_pattern.len != '0) && !is_nul) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fin   <= 1'b0;
        end else if (proc) begin
            r_count <= n_count;
            r_fin   <= n_fin;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out_found <= emit_found;
            r_out_pos   <= MATCH_POS_W'(emit_pos);
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.found          = r_out_found;
    assign o_res.match_position = r_out_pos;

`ifndef NO_ASSERTIONS
    // A not-found result always reports position zero
    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_found || (r_out_pos == '0)))
        else $error("not-found result with nonzero position");

    // A held result with a pending item blocks the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready && r_in_valid) |-> !i_hay.ready)
        else $error("input taken while result slot is full");

    // A string terminator always restarts the count
    a_nul_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && is_nul) |=> (r_count == '0) && !r_fin)
        else $error("count or finished flag survived a NUL");

    // A match on a non-NUL byte enters the swallow state
    a_found_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && emit && emit_found && !is_nul) |=> r_fin)
        else $error("match did not set finished flag");
`endif

endmodule

>>> design/substring_search_first_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_first_match_core
// First-match substring search over a streamed NUL-terminated haystack.
// ----------------------------------------------------------------------------
// Usage:
//   i_hay carries one haystack byte per item; a zero byte ends a string.
//   o_res carries at most one result per string: found=1 with the start
//   offset of the first match, or found=0 (position 0) when the NUL is
//   reached without a match. Bytes after a match, up to and including the
//   NUL, produce no result.
//   The needle is loaded through i_cfg_we / i_cfg_index / i_cfg_data while
//   the block is idle; it reaches the search via the aligned pattern register.
//   A byte passes the input register, then the result register, before its
//   result is presented. Throughput: one byte per cycle while o_res is not
//   stalled, set by the 32-byte parallel window compare.
//   Stall: while o_res holds an untaken result, one more byte can sit in
//   the input register; after that i_hay.ready drops until o_res drains.
//   Reset (synchronous, active low) clears the needle, the count and the
//   finished flag; both channels come up empty.
// ----------------------------------------------------------------------------
module substring_search_first_match_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ssfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ssfm_byte_if.sink                       i_hay,
    ssfm_result_if.source                   o_res
);
    import ssfm_pkg::*;

    t_pattern pattern;

    // Needle registers and aligned pattern
    ssfm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pattern   (pattern)
    );

    // Streaming window search
    ssfm_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pattern (pattern),
        .i_hay     (i_hay),
        .o_res     (o_res)
    );

endmodule

>>> bench/substring_search_first_match_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_first_match_core_test
// Self-checking bench for the streamed first-match substring search core.
// A queue-fed driver streams NUL-terminated haystack strings into i_hay.
// A clocked monitor drains o_res and compares every result with a scoreboard.
// The scoreboard is filled by a search predictor that runs on each accepted
// byte. Needles are reloaded between phases while the core is idle. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module substring_search_first_match_core_test;
    import ssfm_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 155;
    localparam int RANDOM_PHASES = 8;

    typedef struct {
        logic [BYTE_W-1:0] hay_byte;
        bit                drain_first;  // hold until all results are in
    } t_hay_item;

    typedef struct {
        logic                   found;
        logic [MATCH_POS_W-1:0] match_position;
    } t_search_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ssfm_byte_if   hay_ch ();
    ssfm_result_if res_ch ();

    substring_search_first_match_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_hay       (hay_ch),
        .o_res       (res_ch)
    );

    // Stimulus and scoreboard
    t_hay_item      haystack_queue[$];
    t_search_result pending_results[$];
    t_search_result oldest_result;
    int             error_count;
    int             cycle_count;
    int             phase_pushed;
    int             send_gap;
    int             stall_left;
    bit             idle_on;
    bit             alpha_small;
    bit             drain_next;

    // Predictor copy of the configuration and search state
    logic [LEN_W-1:0]      needle_len;
    logic [CFG_DATA_W-1:0] needle_words [CFG_WORDS];
    logic [BYTE_W-1:0]     window [MAX_NEEDLE];
    logic [POSITION_BITS-1:0] bytes_seen;
    bit                    search_done;

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int clamped_len();
        return (needle_len > MAX_NEEDLE) ? MAX_NEEDLE : int'(needle_len);
    endfunction

    function automatic logic [BYTE_W-1:0] needle_byte(input int k);
        return needle_words[k / WORD_BYTES][(k % WORD_BYTES) * 8 +: 8];
    endfunction

    function automatic void clear_string();
        foreach (window[k]) window[k] = '0;
        bytes_seen = '0;
    endfunction

    function automatic void expect_result(input logic found, input logic [31:0] pos);
        t_search_result r;
        r.found          = found;
        r.match_position = pos;
        pending_results.push_back(r);
    endfunction

    // Search predictor: one accepted haystack byte in, zero or one result out
    function automatic void predict_search(input logic [BYTE_W-1:0] b);
        int len;
        bit hit;
        len = clamped_len();
        if (search_done) begin
            if (b == 0) begin
                search_done = 1'b0;
                clear_string();
            end
            return;
        end
        // empty needle matches at offset 0 on the first byte
        if (len == 0) begin
            expect_result(1'b1, '0);
            if (b == 0) clear_string();
            else search_done = 1'b1;
            return;
        end
        if (b == 0) begin
            expect_result(1'b0, '0);
            clear_string();
            return;
        end
        for (int k = MAX_NEEDLE - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = b;
        if (bytes_seen != '1) bytes_seen++;
        if (bytes_seen < len) return;
        hit = 1'b1;
        for (int j = 0; j < len; j++)
            if (window[len-1-j] != needle_byte(j)) hit = 1'b0;
        if (hit) begin
            expect_result(1'b1, MATCH_POS_W'(bytes_seen - len));
            search_done = 1'b1;
        end
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // Byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hay_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (hay_ch.valid && hay_ch.ready) predict_search(hay_ch.haystack_byte);
            if (!hay_ch.valid || hay_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    hay_ch.valid <= 1'b0;
                end else if (haystack_queue.size() > 0 &&
                             !(haystack_queue[0].drain_first &&
                               pending_results.size() > 0)) begin
                    hay_ch.valid         <= 1'b1;
                    hay_ch.haystack_byte <= haystack_queue[0].hay_byte;
                    void'(haystack_queue.pop_front());
                    send_gap = pick_gap();
                end else begin
                    hay_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: found %0d, match_position %0d",
                           res_ch.found, res_ch.match_position);
                    error_count++;
                end else begin
                    oldest_result = pending_results.pop_front();
                    if (res_ch.found !== oldest_result.found) begin
                        $error("found: expected %0d, actual %0d",
                               oldest_result.found, res_ch.found);
                        error_count++;
                    end
                    if (res_ch.match_position !== oldest_result.match_position) begin
                        $error("match_position: expected %0d, actual %0d",
                               oldest_result.match_position, res_ch.match_position);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        t_hay_item it;
        it.hay_byte    = b;
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        haystack_queue.push_back(it);
        phase_pushed++;
    endfunction

    function automatic void queue_text(input string s);
        for (int k = 0; k < s.len(); k++) push_byte(s[k]);
        push_byte(8'h00);
    endfunction

    // Filler byte, never NUL; leans on the needle's own bytes for near misses
    function automatic logic [BYTE_W-1:0] filler_byte();
        logic [BYTE_W-1:0] b;
        if (alpha_small && $urandom_range(0, 3) != 0)
            return 8'h61 + BYTE_W'($urandom_range(0, 3));
        if (clamped_len() > 0 && $urandom_range(0, 2) == 0) begin
            b = needle_byte($urandom_range(0, clamped_len() - 1));
            return (b == 0) ? 8'h01 : b;
        end
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    // One random string: mostly a planted needle, some partial needles and noise
    function automatic void queue_string();
        int kind;
        int pre;
        int len;
        int part;
        len        = clamped_len();
        drain_next = ($urandom_range(0, 29) == 0);
        kind       = $urandom_range(0, 9);
        pre        = $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0) pre = $urandom_range(13, 60);
        for (int k = 0; k < pre; k++) push_byte(filler_byte());
        if (kind <= 5) begin
            for (int k = 0; k < len; k++) push_byte(needle_byte(k));
            if ($urandom_range(0, 3) == 0)
                for (int k = 0; k < len; k++) push_byte(needle_byte(k));
        end else if (kind <= 7 && len > 1) begin
            part = $urandom_range(1, len - 1);
            for (int k = 0; k < part; k++) push_byte(needle_byte(k));
        end else if (kind == 8) begin
            for (int k = $urandom_range(0, 30); k > 0; k--)
                push_byte(BYTE_W'($urandom_range(1, 255)));
        end
        for (int k = $urandom_range(0, 8); k > 0; k--) push_byte(filler_byte());
        push_byte(8'h00);
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_NEEDLE_LENGTH: needle_len      = data[LEN_W-1:0];
            CFG_NEEDLE_LO:     needle_words[0] = data;
            CFG_NEEDLE_MID:    needle_words[1] = data;
            CFG_NEEDLE_HIGH:   needle_words[2] = data;
            CFG_NEEDLE_TOP:    needle_words[3] = data;
            default: ;
        endcase
    endtask

    // Load all needle registers; junk rides in the unused length bits
    task automatic load_needle(input logic [LEN_W-1:0] len, input logic [63:0] w0,
                               input logic [63:0] w1, input logic [63:0] w2,
                               input logic [63:0] w3);
        logic [CFG_DATA_W-1:0] len_word;
        len_word            = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        write_reg(CFG_NEEDLE_LENGTH, len_word);
        write_reg(CFG_NEEDLE_LO, w0);
        write_reg(CFG_NEEDLE_MID, w1);
        write_reg(CFG_NEEDLE_HIGH, w2);
        write_reg(CFG_NEEDLE_TOP, w3);
        repeat (2) @(posedge i_clk);
    endtask

    // Random needle; bytes past the length are junk, sometimes a NUL inside
    task automatic load_random_needle(input int len6);
        logic [BYTE_W-1:0]     nb [MAX_NEEDLE];
        logic [CFG_DATA_W-1:0] w [CFG_WORDS];
        int                    len;
        len = (len6 > MAX_NEEDLE) ? MAX_NEEDLE : len6;
        foreach (nb[k]) nb[k] = BYTE_W'($urandom_range(0, 255));
        for (int k = 0; k < len; k++)
            nb[k] = alpha_small ? 8'h61 + BYTE_W'($urandom_range(0, 3))
                                : BYTE_W'($urandom_range(1, 255));
        if (len > 0 && $urandom_range(0, 5) == 0) nb[$urandom_range(0, len - 1)] = 8'h00;
        foreach (nb[k]) w[k / WORD_BYTES][(k % WORD_BYTES) * 8 +: 8] = nb[k];
        load_needle(LEN_W'(len6), w[0], w[1], w[2], w[3]);
    endtask

    // Idle: nothing queued or on the wire, no result outstanding
    task automatic wait_idle();
        do @(negedge i_clk);
        while (haystack_queue.size() != 0 || hay_ch.valid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Test sequence
    initial begin
        int len6;
        error_count  = 0;
        cycle_count  = 0;
        idle_on      = 1'b1;
        alpha_small  = 1'b0;
        drain_next   = 1'b0;
        needle_len   = '0;
        foreach (needle_words[k]) needle_words[k] = '0;
        search_done  = 1'b0;
        clear_string();
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = CFG_NEEDLE_LENGTH;
        i_cfg_data           = '0;
        hay_ch.valid         = 1'b0;
        hay_ch.haystack_byte = '0;
        res_ch.ready         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Empty needle out of reset: NUL-only string, then a swallowed tail
        queue_text("");
        queue_text("x");
        push_byte(8'hFF);
        push_byte(8'h00);
        wait_idle();

        // Short needle with junk past its length
        load_needle(LEN_W'(3), 64'hDEAD_BEEF_0063_6261, '1, '1, '1);
        queue_text("abc");
        drain_next = 1'b1;
        queue_text("xabcz");
        queue_text("ab");
        push_byte(8'hFF);
        push_byte(8'h00);
        wait_idle();

        // Needle holding a NUL never matches
        load_needle(LEN_W'(2), 64'h0000_0000_0000_0061, '0, '0, '0);
        queue_text("a");
        wait_idle();

        // Random phases: full-length, oversized, single-byte, empty, then random
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: len6 = MAX_NEEDLE;
                1: len6 = (1 << LEN_W) - 1;
                2: len6 = 1;
                3: len6 = 0;
                default: len6 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(1, 12);
            endcase
            alpha_small = (p == 2) ? 1'b1 : 1'($urandom_range(0, 1));
            idle_on     = (p != 4);
            load_random_needle(len6);
            phase_pushed = 0;
            while (phase_pushed < PHASE_ITEMS) queue_string();
            wait_idle();
        end

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
